### design/drt_pkg.sv
package drt_pkg;

  // Default prescaler length in cycles.
  localparam int unsigned PRESCALE_DEF = 20;

  // Operation codes.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Register select codes.
  localparam logic [3:0] REG_CNT0_LO = 4'd0;
  localparam logic [3:0] REG_CNT0_HI = 4'd1;
  localparam logic [3:0] REG_RLD0_LO = 4'd2;
  localparam logic [3:0] REG_RLD0_HI = 4'd3;
  localparam logic [3:0] REG_CTRL    = 4'd4;
  localparam logic [3:0] REG_CNT1_LO = 4'd5;
  localparam logic [3:0] REG_CNT1_HI = 4'd6;
  localparam logic [3:0] REG_RLD1_LO = 4'd7;
  localparam logic [3:0] REG_RLD1_HI = 4'd8;

  // Bit positions in the writable part of the control register.
  localparam int unsigned CTRL_EN0  = 0;
  localparam int unsigned CTRL_EN1  = 1;
  localparam int unsigned CTRL_IRQ0 = 4;
  localparam int unsigned CTRL_IRQ1 = 5;
  localparam int unsigned CTRL_W    = 6;

  // Low five bits of the interrupt vector for each timer.
  localparam logic [4:0] VEC_TIMER0 = 5'h04;
  localparam logic [4:0] VEC_TIMER1 = 5'h06;

  // Reset value of counts and reloads.
  localparam logic [15:0] CNT_RESET = 16'hffff;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] reg_select;
    logic [7:0] write_data;
    logic [7:0] elapsed_cycles;
    logic       cpu_can_take;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_request;
    logic [7:0] irq_vector;
  } out_t;

endpackage

### design/dual_reload_timer.sv
// Channel  | Direction | Signals                              | Payload
// ---------+-----------+--------------------------------------+----------------
// request  | in        | in_valid_i, in_stall_o, in_data_i    | drt_pkg::in_t
// result   | out       | out_valid_o, out_stall_i, out_data_o | drt_pkg::out_t
// config   | in        | cfg_we_i, cfg_data_i                 | vector base
//
// A read, write or unused request passes S_EXEC and S_DONE; a tick passes
// S_EXEC, S_LOAD per timer, S_WRAP per enabled timer and S_DONE. The single
// subtract-and-compare unit that steps the prescaler handles one wrap per
// cycle. No request is accepted until the sequencer is back in S_IDLE. Reset
// clears all state at once. A result waits in the output register while
// out_stall_i is high; the finished request waits until it is free.
module dual_reload_timer #(
  parameter int unsigned PRESCALE = drt_pkg::PRESCALE_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  drt_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output drt_pkg::out_t  out_data_o,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_data_i
);

  // Accumulator holds values below PRESCALE; the sum adds one elapsed byte.
  localparam int unsigned ACC_W = (PRESCALE > 1) ? $clog2(PRESCALE) : 1;
  localparam int unsigned SUM_W = $clog2(PRESCALE + 256);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_WRAP,
    S_DONE
  } state_e;

  state_e                      state_q, state_d;
  drt_pkg::in_t                req_q, req_d;
  logic                        ch_q, ch_d;
  logic [SUM_W-1:0]            sum_q, sum_d;
  logic [ACC_W-1:0]            acc_q [2];
  logic [ACC_W-1:0]            acc_d [2];
  logic [15:0]                 cnt_q [2];
  logic [15:0]                 cnt_d [2];
  logic [15:0]                 rld_q [2];
  logic [15:0]                 rld_d [2];
  logic [drt_pkg::CTRL_W-1:0]  ctrl_q, ctrl_d;
  logic [1:0]                  flag_q, flag_d;
  logic [1:0]                  cread_q, cread_d;
  logic [2:0]                  vbase_q, vbase_d;
  logic [7:0]                  rd_q, rd_d;
  logic                        out_valid_q, out_valid_d;
  drt_pkg::out_t               out_q, out_d;

  logic                        ch_en;
  logic [15:0]                 cnt_step;
  logic                        wrap;
  logic                        irq0, irq1;

  // Shared step unit: enable of the current timer, next count, wrap compare.
  always_comb begin
    ch_en    = ch_q ? ctrl_q[drt_pkg::CTRL_EN1] : ctrl_q[drt_pkg::CTRL_EN0];
    cnt_step = (cnt_q[ch_q] == 16'd0) ? rld_q[ch_q] : (cnt_q[ch_q] - 16'd1);
    wrap     = (sum_q >= SUM_W'(PRESCALE));
    irq0     = flag_q[0] && ctrl_q[drt_pkg::CTRL_IRQ0];
    irq1     = flag_q[1] && ctrl_q[drt_pkg::CTRL_IRQ1];
  end

  // Sequencer and register file next state.
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    ch_d        = ch_q;
    sum_d       = sum_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    rld_d       = rld_q;
    ctrl_d      = ctrl_q;
    flag_d      = flag_q;
    cread_d     = cread_q;
    vbase_d     = cfg_we_i ? cfg_data_i : vbase_q;
    rd_d        = rd_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        rd_d    = 8'd0;
        ch_d    = 1'b0;
        state_d = S_DONE;
        if (req_q.op == drt_pkg::OP_TICK) begin
          state_d = S_LOAD;
        end else if (req_q.op == drt_pkg::OP_READ) begin
          unique case (req_q.reg_select)
            drt_pkg::REG_CNT0_LO: begin
              rd_d = cnt_q[0][7:0];
              if (cread_q[0]) begin
                flag_d[0]  = 1'b0;
                cread_d[0] = 1'b0;
              end
            end
            drt_pkg::REG_CNT0_HI: begin
              rd_d = cnt_q[0][15:8];
              if (cread_q[0]) begin
                flag_d[0]  = 1'b0;
                cread_d[0] = 1'b0;
              end
            end
            drt_pkg::REG_RLD0_LO: rd_d = rld_q[0][7:0];
            drt_pkg::REG_RLD0_HI: rd_d = rld_q[0][15:8];
            drt_pkg::REG_CTRL: begin
              rd_d    = {flag_q, ctrl_q};
              cread_d = 2'b11;
            end
            drt_pkg::REG_CNT1_LO: begin
              rd_d = cnt_q[1][7:0];
              if (cread_q[1]) begin
                flag_d[1]  = 1'b0;
                cread_d[1] = 1'b0;
              end
            end
            drt_pkg::REG_CNT1_HI: begin
              rd_d = cnt_q[1][15:8];
              if (cread_q[1]) begin
                flag_d[1]  = 1'b0;
                cread_d[1] = 1'b0;
              end
            end
            drt_pkg::REG_RLD1_LO: rd_d = rld_q[1][7:0];
            drt_pkg::REG_RLD1_HI: rd_d = rld_q[1][15:8];
            default: rd_d = 8'd0;
          endcase
        end else if (req_q.op == drt_pkg::OP_WRITE) begin
          unique case (req_q.reg_select)
            drt_pkg::REG_CNT0_LO: begin
              if (!ctrl_q[drt_pkg::CTRL_EN0]) cnt_d[0][7:0] = req_q.write_data;
            end
            drt_pkg::REG_CNT0_HI: begin
              if (!ctrl_q[drt_pkg::CTRL_EN0]) cnt_d[0][15:8] = req_q.write_data;
            end
            drt_pkg::REG_RLD0_LO: rld_d[0][7:0]  = req_q.write_data;
            drt_pkg::REG_RLD0_HI: rld_d[0][15:8] = req_q.write_data;
            drt_pkg::REG_CTRL:    ctrl_d = req_q.write_data[drt_pkg::CTRL_W-1:0];
            drt_pkg::REG_CNT1_LO: begin
              if (!ctrl_q[drt_pkg::CTRL_EN1]) cnt_d[1][7:0] = req_q.write_data;
            end
            drt_pkg::REG_CNT1_HI: begin
              if (!ctrl_q[drt_pkg::CTRL_EN1]) cnt_d[1][15:8] = req_q.write_data;
            end
            drt_pkg::REG_RLD1_LO: rld_d[1][7:0]  = req_q.write_data;
            drt_pkg::REG_RLD1_HI: rld_d[1][15:8] = req_q.write_data;
            default: ;
          endcase
        end
      end

      // Start one timer: add the elapsed cycles, or clear a disabled prescaler.
      S_LOAD: begin
        if (ch_en) begin
          sum_d   = SUM_W'(acc_q[ch_q]) + SUM_W'(req_q.elapsed_cycles);
          state_d = S_WRAP;
        end else begin
          acc_d[ch_q] = '0;
          if (ch_q) begin
            state_d = S_DONE;
          end else begin
            ch_d = 1'b1;
          end
        end
      end

      // One prescaler wrap per cycle until the remainder is below PRESCALE.
      S_WRAP: begin
        if (wrap) begin
          sum_d       = sum_q - SUM_W'(PRESCALE);
          cnt_d[ch_q] = cnt_step;
          if (cnt_step == 16'd0) flag_d[ch_q] = 1'b1;
        end else begin
          acc_d[ch_q] = sum_q[ACC_W-1:0];
          if (ch_q) begin
            state_d = S_DONE;
          end else begin
            ch_d    = 1'b1;
            state_d = S_LOAD;
          end
        end
      end

      // Interrupt decision after the request's effect; wait for a free output.
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d.read_data   = rd_q;
          out_d.irq_request = 1'b0;
          out_d.irq_vector  = 8'd0;
          if (req_q.cpu_can_take && irq0) begin
            out_d.irq_request = 1'b1;
            out_d.irq_vector  = {vbase_q, drt_pkg::VEC_TIMER0};
          end else if (req_q.cpu_can_take && irq1) begin
            out_d.irq_request = 1'b1;
            out_d.irq_vector  = {vbase_q, drt_pkg::VEC_TIMER1};
          end
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State, register file and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      ch_q        <= 1'b0;
      sum_q       <= '0;
      acc_q[0]    <= '0;
      acc_q[1]    <= '0;
      cnt_q[0]    <= drt_pkg::CNT_RESET;
      cnt_q[1]    <= drt_pkg::CNT_RESET;
      rld_q[0]    <= drt_pkg::CNT_RESET;
      rld_q[1]    <= drt_pkg::CNT_RESET;
      ctrl_q      <= '0;
      flag_q      <= '0;
      cread_q     <= '0;
      vbase_q     <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      ch_q        <= ch_d;
      sum_q       <= sum_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      rld_q       <= rld_d;
      ctrl_q      <= ctrl_d;
      flag_q      <= flag_d;
      cread_q     <= cread_d;
      vbase_q     <= vbase_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### tb/tb_dual_reload_timer.sv
`timescale 1ns / 1ps

module tb_dual_reload_timer;

  // Codes outside the package's decoded set, used to probe the ignore paths.
  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam logic [3:0] REG_UNUSED_LO = 4'd9;
  localparam logic [3:0] REG_UNUSED_HI = 4'd15;

  // Read-only flag bits of the control register.
  localparam int unsigned FLAG0_BIT = 6;
  localparam int unsigned FLAG1_BIT = 7;

  localparam int unsigned HOLD_CYCLES = 300;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  drt_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  drt_pkg::out_t out_data_o;
  logic          cfg_we_i = 1'b0;
  logic [2:0]    cfg_data_i = '0;

  // Shadow copy of the timer state, advanced once per accepted request.
  logic [15:0] cnt_shadow [2];
  logic [15:0] rld_shadow [2];
  logic [7:0]  ctrl_shadow;
  int unsigned presc_shadow [2];
  logic        ctrl_seen [2];
  logic [2:0]  vec_base;

  drt_pkg::in_t  pending_reqs [$];
  drt_pkg::out_t expected_results [$];

  int          send_idle = 0;
  int          recv_idle = 0;
  int          hold_kicks = 0;
  int          hold_seen = 0;
  int unsigned hold_left = 0;
  int          mismatches = 0;
  int          reqs_sent = 0;
  int          results_seen = 0;
  int          irq_seen = 0;

  dual_reload_timer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Data register read; a preceding control read makes it clear the flag.
  function automatic logic [7:0] count_read(int ch, bit hi);
    if (ctrl_seen[ch]) begin
      ctrl_shadow[FLAG0_BIT + ch] = 1'b0;
      ctrl_seen[ch] = 1'b0;
    end
    return hi ? cnt_shadow[ch][15:8] : cnt_shadow[ch][7:0];
  endfunction

  // Data register write, dropped while the channel runs.
  function automatic void count_write(int ch, bit hi, logic [7:0] v);
    if (ctrl_shadow[(ch == 0) ? drt_pkg::CTRL_EN0 : drt_pkg::CTRL_EN1]) begin
      return;
    end
    if (hi) begin
      cnt_shadow[ch][15:8] = v;
    end else begin
      cnt_shadow[ch][7:0] = v;
    end
  endfunction

  function automatic void reload_write(int ch, bit hi, logic [7:0] v);
    if (hi) begin
      rld_shadow[ch][15:8] = v;
    end else begin
      rld_shadow[ch][7:0] = v;
    end
  endfunction

  // Applies one request to the shadow state and returns the result it gives.
  function automatic drt_pkg::out_t timer_step(drt_pkg::in_t req);
    drt_pkg::out_t res;
    int            en_bit;
    int            flag_bit;
    res = '0;
    case (req.op)
      drt_pkg::OP_TICK: begin
        for (int ch = 0; ch < 2; ch++) begin
          en_bit = (ch == 0) ? drt_pkg::CTRL_EN0 : drt_pkg::CTRL_EN1;
          flag_bit = FLAG0_BIT + ch;
          if (!ctrl_shadow[en_bit]) begin
            presc_shadow[ch] = 0;
          end else begin
            presc_shadow[ch] += req.elapsed_cycles;
            while (presc_shadow[ch] >= drt_pkg::PRESCALE_DEF) begin
              presc_shadow[ch] -= drt_pkg::PRESCALE_DEF;
              if (cnt_shadow[ch] == 16'd0) begin
                cnt_shadow[ch] = rld_shadow[ch];
              end else begin
                cnt_shadow[ch] = cnt_shadow[ch] - 16'd1;
              end
              if (cnt_shadow[ch] == 16'd0) begin
                ctrl_shadow[flag_bit] = 1'b1;
              end
            end
          end
        end
      end
      drt_pkg::OP_READ: begin
        case (req.reg_select)
          drt_pkg::REG_CNT0_LO: res.read_data = count_read(0, 1'b0);
          drt_pkg::REG_CNT0_HI: res.read_data = count_read(0, 1'b1);
          drt_pkg::REG_RLD0_LO: res.read_data = rld_shadow[0][7:0];
          drt_pkg::REG_RLD0_HI: res.read_data = rld_shadow[0][15:8];
          drt_pkg::REG_CTRL: begin
            ctrl_seen[0] = 1'b1;
            ctrl_seen[1] = 1'b1;
            res.read_data = ctrl_shadow;
          end
          drt_pkg::REG_CNT1_LO: res.read_data = count_read(1, 1'b0);
          drt_pkg::REG_CNT1_HI: res.read_data = count_read(1, 1'b1);
          drt_pkg::REG_RLD1_LO: res.read_data = rld_shadow[1][7:0];
          drt_pkg::REG_RLD1_HI: res.read_data = rld_shadow[1][15:8];
          default: ;
        endcase
      end
      drt_pkg::OP_WRITE: begin
        case (req.reg_select)
          drt_pkg::REG_CNT0_LO: count_write(0, 1'b0, req.write_data);
          drt_pkg::REG_CNT0_HI: count_write(0, 1'b1, req.write_data);
          drt_pkg::REG_RLD0_LO: reload_write(0, 1'b0, req.write_data);
          drt_pkg::REG_RLD0_HI: reload_write(0, 1'b1, req.write_data);
          drt_pkg::REG_CTRL: begin
            ctrl_shadow[drt_pkg::CTRL_W-1:0] = req.write_data[drt_pkg::CTRL_W-1:0];
          end
          drt_pkg::REG_CNT1_LO: count_write(1, 1'b0, req.write_data);
          drt_pkg::REG_CNT1_HI: count_write(1, 1'b1, req.write_data);
          drt_pkg::REG_RLD1_LO: reload_write(1, 1'b0, req.write_data);
          drt_pkg::REG_RLD1_HI: reload_write(1, 1'b1, req.write_data);
          default: ;
        endcase
      end
      default: ;
    endcase
    // Interrupt decision after the request's own effect; timer0 wins.
    if (req.cpu_can_take) begin
      if (ctrl_shadow[FLAG0_BIT] && ctrl_shadow[drt_pkg::CTRL_IRQ0]) begin
        res.irq_request = 1'b1;
        res.irq_vector = {vec_base, drt_pkg::VEC_TIMER0};
      end else if (ctrl_shadow[FLAG1_BIT] && ctrl_shadow[drt_pkg::CTRL_IRQ1]) begin
        res.irq_request = 1'b1;
        res.irq_vector = {vec_base, drt_pkg::VEC_TIMER1};
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic push_req(logic [1:0] op, logic [3:0] sel, logic [7:0] wd,
                          logic [7:0] cyc, logic take);
    drt_pkg::in_t req;
    req.op = op;
    req.reg_select = sel;
    req.write_data = wd;
    req.elapsed_cycles = cyc;
    req.cpu_can_take = take;
    pending_reqs.insert(pending_reqs.size(), req);
  endtask

  // Mostly programs a channel with a short count and lets it run out, with
  // flag clearing reads and some noise in between.
  task automatic push_random(int n);
    int          left;
    int          pick;
    int          ch;
    logic [7:0]  ctrl_v;
    logic        take;
    left = n;
    while (left > 0) begin
      pick = $urandom_range(99);
      take = ($urandom_range(3) != 0);
      ch = $urandom_range(1);
      if (pick < 14) begin
        ctrl_v = 8'($urandom);
        ctrl_v[(ch == 0) ? drt_pkg::CTRL_EN0 : drt_pkg::CTRL_EN1] = 1'b0;
        push_req(drt_pkg::OP_WRITE, drt_pkg::REG_CTRL, ctrl_v, 8'($urandom), take);
        push_req(drt_pkg::OP_WRITE, (ch == 0) ? drt_pkg::REG_CNT0_LO : drt_pkg::REG_CNT1_LO,
                 ($urandom_range(1) != 0) ? 8'($urandom_range(40)) : 8'($urandom),
                 8'($urandom), take);
        push_req(drt_pkg::OP_WRITE, (ch == 0) ? drt_pkg::REG_CNT0_HI : drt_pkg::REG_CNT1_HI,
                 ($urandom_range(5) == 0) ? 8'($urandom) : 8'd0, 8'($urandom), take);
        push_req(drt_pkg::OP_WRITE, (ch == 0) ? drt_pkg::REG_RLD0_LO : drt_pkg::REG_RLD1_LO,
                 8'($urandom_range(60)), 8'($urandom), take);
        push_req(drt_pkg::OP_WRITE, (ch == 0) ? drt_pkg::REG_RLD0_HI : drt_pkg::REG_RLD1_HI,
                 ($urandom_range(7) == 0) ? 8'($urandom) : 8'd0, 8'($urandom), take);
        ctrl_v = 8'($urandom);
        ctrl_v[(ch == 0) ? drt_pkg::CTRL_EN0 : drt_pkg::CTRL_EN1] = 1'b1;
        if ($urandom_range(3) != 0) begin
          ctrl_v[drt_pkg::CTRL_IRQ0] = 1'b1;
          ctrl_v[drt_pkg::CTRL_IRQ1] = 1'b1;
        end
        push_req(drt_pkg::OP_WRITE, drt_pkg::REG_CTRL, ctrl_v, 8'($urandom), take);
        left -= 6;
      end else if (pick < 60) begin
        push_req(drt_pkg::OP_TICK, 4'($urandom), 8'($urandom),
                 ($urandom_range(4) == 0) ? 8'($urandom_range(25)) : 8'($urandom), take);
        left -= 1;
      end else if (pick < 74) begin
        push_req(drt_pkg::OP_READ, drt_pkg::REG_CTRL, 8'($urandom), 8'($urandom), take);
        if (ch == 0) begin
          push_req(drt_pkg::OP_READ,
                   ($urandom_range(1) != 0) ? drt_pkg::REG_CNT0_HI : drt_pkg::REG_CNT0_LO,
                   8'($urandom), 8'($urandom), 1'($urandom_range(1)));
        end else begin
          push_req(drt_pkg::OP_READ,
                   ($urandom_range(1) != 0) ? drt_pkg::REG_CNT1_HI : drt_pkg::REG_CNT1_LO,
                   8'($urandom), 8'($urandom), 1'($urandom_range(1)));
        end
        left -= 2;
      end else if (pick < 85) begin
        push_req(drt_pkg::OP_READ, 4'($urandom), 8'($urandom), 8'($urandom), take);
        left -= 1;
      end else if (pick < 94) begin
        push_req(drt_pkg::OP_WRITE, 4'($urandom), 8'($urandom), 8'($urandom), take);
        left -= 1;
      end else begin
        push_req(OP_UNUSED, 4'($urandom), 8'($urandom), 8'($urandom), take);
        left -= 1;
      end
    end
  endtask

  // Waits until every request has gone in and every result has come out.
  task automatic wait_quiet();
    do begin
      @(negedge clk_i);
    end while (pending_reqs.size() != 0 || in_valid_i || expected_results.size() != 0);
  endtask

  task automatic set_vector_base(logic [2:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    vec_base = v;
    @(negedge clk_i);
  endtask

  // Request driver: offers queued requests with random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        expected_results.insert(expected_results.size(), timer_step(in_data_i));
        reqs_sent++;
      end
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_reqs[0];
        pending_reqs.delete(0);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, started on request from the stimulus.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_kicks) begin
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_kicks;
    end
  end

  // Result monitor: random stalls and a field by field check.
  always @(posedge clk_i) begin
    drt_pkg::out_t want;
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (out_data_o.irq_request) begin
        irq_seen++;
      end
      if (expected_results.size() == 0) begin
        report_mismatch("result arrived with nothing expected");
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (out_data_o.read_data !== want.read_data) begin
          report_mismatch($sformatf("read_data got %h want %h",
                                    out_data_o.read_data, want.read_data));
        end
        if (out_data_o.irq_request !== want.irq_request) begin
          report_mismatch($sformatf("irq_request got %b want %b",
                                    out_data_o.irq_request, want.irq_request));
        end
        if (out_data_o.irq_vector !== want.irq_vector) begin
          report_mismatch($sformatf("irq_vector got %h want %h",
                                    out_data_o.irq_vector, want.irq_vector));
        end
      end
    end
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_idle);
  end

  initial begin
    cnt_shadow[0] = drt_pkg::CNT_RESET;
    cnt_shadow[1] = drt_pkg::CNT_RESET;
    rld_shadow[0] = drt_pkg::CNT_RESET;
    rld_shadow[1] = drt_pkg::CNT_RESET;
    ctrl_shadow = '0;
    presc_shadow[0] = 0;
    presc_shadow[1] = 0;
    ctrl_seen[0] = 1'b0;
    ctrl_seen[1] = 1'b0;
    vec_base = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: reset values, zero reach on both timers, priority,
    // flag clearing, writes while enabled and unused codes.
    send_idle = 16;
    recv_idle = 61;
    set_vector_base(3'd7);
    push_req(drt_pkg::OP_READ,  drt_pkg::REG_CTRL,    8'h00, 8'h00, 1'b1);
    push_req(drt_pkg::OP_READ,  drt_pkg::REG_CNT0_LO, 8'h00, 8'h00, 1'b1);
    push_req(drt_pkg::OP_READ,  drt_pkg::REG_RLD1_HI, 8'h00, 8'h00, 1'b0);
    push_req(drt_pkg::OP_TICK,  drt_pkg::REG_CTRL,    8'hff, 8'hff, 1'b1);
    push_req(drt_pkg::OP_WRITE, drt_pkg::REG_CNT0_LO, 8'h01, 8'h00, 1'b1);
    push_req(drt_pkg::OP_WRITE, drt_pkg::REG_CNT0_HI, 8'h00, 8'h00, 1'b1);
    push_req(drt_pkg::OP_WRITE, drt_pkg::REG_RLD0_LO, 8'h02, 8'h00, 1'b1);
    push_req(drt_pkg::OP_WRITE, drt_pkg::REG_RLD0_HI, 8'h00, 8'h00, 1'b1);
    push_req(drt_pkg::OP_WRITE, drt_pkg::REG_CNT1_LO, 8'h01, 8'h00, 1'b1);
    push_req(drt_pkg::OP_WRITE, drt_pkg::REG_CNT1_HI, 8'h00, 8'h00, 1'b1);
    push_req(drt_pkg::OP_WRITE, drt_pkg::REG_CTRL,    8'hff, 8'h00, 1'b1);
    push_req(drt_pkg::OP_WRITE, drt_pkg::REG_CNT0_LO, 8'h55, 8'h00, 1'b1);
    push_req(drt_pkg::OP_TICK,  drt_pkg::REG_CNT0_LO, 8'h00, 8'd19, 1'b1);
    push_req(drt_pkg::OP_TICK,  drt_pkg::REG_CNT0_LO, 8'h00, 8'd1,  1'b1);
    push_req(drt_pkg::OP_READ,  drt_pkg::REG_CTRL,    8'h00, 8'h00, 1'b1);
    push_req(drt_pkg::OP_READ,  drt_pkg::REG_CNT0_HI, 8'h00, 8'h00, 1'b1);
    push_req(drt_pkg::OP_READ,  drt_pkg::REG_CNT1_LO, 8'h00, 8'h00, 1'b0);
    push_req(drt_pkg::OP_TICK,  drt_pkg::REG_CNT0_LO, 8'h00, 8'hff, 1'b1);
    push_req(drt_pkg::OP_WRITE, drt_pkg::REG_CTRL,    8'h00, 8'h00, 1'b1);
    push_req(drt_pkg::OP_WRITE, drt_pkg::REG_CNT0_HI, 8'h80, 8'h00, 1'b1);
    push_req(drt_pkg::OP_READ,  drt_pkg::REG_CNT0_HI, 8'h00, 8'h00, 1'b1);
    push_req(drt_pkg::OP_READ,  REG_UNUSED_HI,        8'h00, 8'h00, 1'b1);
    push_req(drt_pkg::OP_WRITE, REG_UNUSED_LO,        8'haa, 8'h00, 1'b1);
    push_req(OP_UNUSED,         REG_UNUSED_HI,        8'hff, 8'hff, 1'b1);
    push_req(drt_pkg::OP_TICK,  drt_pkg::REG_CNT0_LO, 8'h00, 8'h00, 1'b0);
    wait_quiet();

    // Random phases, one vector base each.
    set_vector_base(3'd0);
    push_random(240);
    wait_quiet();

    send_idle = 61;
    recv_idle = 16;
    set_vector_base(3'd3);
    push_random(230);
    wait_quiet();

    // No idling, but one long receiver hold-off so the block backs up.
    send_idle = 0;
    recv_idle = 0;
    set_vector_base(3'd5);
    push_random(230);
    hold_kicks++;
    wait_quiet();

    repeat (50) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    end
    $display("Sent %0d requests over four phases with vector bases 7, 0, 3 and 5.",
             reqs_sent);
    $display("Checked %0d results, %0d of them interrupt requests; %0d mismatches.",
             results_seen, irq_seen, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog in case the block hangs.
  initial begin
    #2_000_000;
    $display("Timeout at %0t", $time);
    $display("Some tests failed");
    $finish;
  end

endmodule
